// ----- hdl/llrf_pkg.sv -----
// shared types and constants of the light level ratio filter
`default_nettype none

package llrf_pkg;

  // datapath widths
  localparam int DIV_W    = 16;  // divisor and remainder
  localparam int DVD_W    = 32;  // dividend / quotient shift register
  localparam int PROD_W   = 32;  // multiplier product
  localparam int V_W      = 19;  // mapped light value
  localparam int HELD_W   = 20;  // half-step average level
  localparam int SUM_W    = 27;  // leaky window sum
  localparam int CNT_W    = 8;   // window sample count
  localparam int SHIFT_W  = 3;   // window shift
  localparam int DCNT_W   = 5;   // divider step counter
  localparam int LEVEL_W  = 19;  // result width

  // divider step counts
  localparam logic [DCNT_W-1:0] RATIO_STEPS = DCNT_W'(16);
  localparam logic [DCNT_W-1:0] SUM_STEPS   = DCNT_W'(SUM_W);

  // output saturation
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(524272);

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_SHIFT   = CFG_IDX_W'(1);
  localparam logic [SHIFT_W-1:0]   AVG_SHIFT_RESET = SHIFT_W'(2);

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_R,
    ST_SQ1,
    ST_SQ2,
    ST_VAL,
    ST_FILT,
    ST_DIV_S,
    ST_QUOT,
    ST_DONE
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;    // capture samples
    logic div_ratio;  // load divider with ratio operands
    logic div_sum;    // load divider with window average operands
    logic div_step;   // one restoring division step
    logic mul_r;      // square the ratio
    logic mul_q;      // square the first square
    logic take_v;     // keep mapped value from product
    logic zero_v;     // mapped value is zero
    logic filt;       // update the smoothing state
    logic take_quot;  // result from divider quotient
    logic out_load;   // load output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pos;        // supply above sense, sense nonzero
    logic div_last;   // divider on its last step
    logic need_div;   // warm-up average needs a division
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/llrf_ctrl.sv -----
// sequencing state machine of the light level ratio filter
`default_nettype none

module llrf_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  input  wire llrf_pkg::status_t  status_i,
  output llrf_pkg::cmd_t          cmd_o
);
  import llrf_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        if (status_i.pos) begin
          cmd_o.div_ratio = 1'b1;
          state_d         = ST_DIV_R;
        end else begin
          cmd_o.zero_v = 1'b1;
          state_d      = ST_FILT;
        end
      end
      ST_DIV_R: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_SQ1;
        end
      end
      ST_SQ1: begin
        cmd_o.mul_r = 1'b1;
        state_d     = ST_SQ2;
      end
      ST_SQ2: begin
        cmd_o.mul_q = 1'b1;
        state_d     = ST_VAL;
      end
      ST_VAL: begin
        cmd_o.take_v = 1'b1;
        state_d      = ST_FILT;
      end
      ST_FILT: begin
        cmd_o.filt = 1'b1;
        if (status_i.need_div) begin
          cmd_o.div_sum = 1'b1;
          state_d       = ST_DIV_S;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV_S: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_QUOT;
        end
      end
      ST_QUOT: begin
        cmd_o.take_quot = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid: set on load, cleared when the transaction completes
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

`ifndef SYNTHESIS
  // a finished result is always presented once the slot frees up
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> out_valid_q)
    else $error("finished result not presented");

  // an accepted input transaction starts the sequence
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_PREP))
    else $error("accepted input did not start processing");
`endif

endmodule

`default_nettype wire

// ----- hdl/llrf_dp.sv -----
// datapath: shared divider, shared multiplier, smoothing state and output register
`default_nettype none

module llrf_dp #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire  [15:0]                          supply_sample_i,
  input  wire  [15:0]                          sense_sample_i,
  input  wire                                  cfg_valid_i,
  input  wire  [llrf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [llrf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire  llrf_pkg::cmd_t                 cmd_i,
  output llrf_pkg::status_t                    status_o,
  output logic [llrf_pkg::LEVEL_W-1:0]         light_level_o
);
  import llrf_pkg::*;

  // samples
  logic [SAMPLE_WIDTH-1:0] supply_q, sense_q;
  logic [SAMPLE_WIDTH-1:0] diff;

  // configuration
  logic               mode_q;
  logic [SHIFT_W-1:0] shift_q;

  // divider
  logic [DIV_W-1:0]  rem_q, dsor_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [DIV_W:0]    rem_sh, rem_sub;
  logic              rem_ge;

  // multiplier
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [15:0]       mul_a;

  // mapped value and smoothing state
  logic [V_W-1:0]     v_q;
  logic [HELD_W-1:0]  held_q, held_base, held_sum, held_nx;
  logic [LEVEL_W-1:0] held_half;
  logic [SUM_W-1:0]   sum_q, sum_new, avg;
  logic [CNT_W-1:0]   cnt_q, cnt_new;
  logic [CNT_W:0]     window;
  logic               leaky;

  // result and output
  logic [SUM_W-1:0]   res_q;
  logic [LEVEL_W-1:0] level_q;

  assign diff = supply_q - sense_q;

  // restoring division step
  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dsor_q});
  assign rem_sub = rem_sh - {1'b0, dsor_q};

  // squaring: ratio first, then the upper half of the first square
  assign mul_a  = cmd_i.mul_q ? prod_q[PROD_W-1:16] : dvd_q[15:0];
  assign prod_d = mul_a * mul_a;

  // half-step recursive average
  assign held_base = (held_q == '0) ? HELD_W'(v_q) : held_q;
  assign held_sum  = held_base + HELD_W'(v_q);
  assign held_half = held_sum[HELD_W-1:1];
  assign held_nx   = held_sum - HELD_W'(held_half);

  // shift-window running average
  assign sum_new = sum_q + SUM_W'(v_q);
  assign cnt_new = cnt_q + CNT_W'(1);
  assign window  = (CNT_W+1)'(1) << shift_q;
  assign leaky   = ({1'b0, cnt_new} >= window);
  assign avg     = sum_new >> shift_q;

  // a zero sense gives a ratio of 2^16 whose square wraps to zero
  assign status_o.pos      = (supply_q > sense_q) && (sense_q != '0);
  assign status_o.div_last = (dcnt_q == DCNT_W'(1));
  assign status_o.need_div = mode_q && !leaky && (cnt_new != '0);

  assign light_level_o = level_q;

  // configuration, filter state and divider counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      shift_q <= AVG_SHIFT_RESET;
      held_q  <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_FILTER_MODE: mode_q  <= cfg_data_i[0];
          CFG_AVG_SHIFT:   shift_q <= cfg_data_i[SHIFT_W-1:0];
          default:         ;
        endcase
      end
      if (cmd_i.filt) begin
        if (!mode_q) begin
          held_q <= held_nx;
        end else if (leaky) begin
          sum_q <= sum_new - avg;
          cnt_q <= cnt_new - CNT_W'(1);
        end else begin
          sum_q <= sum_new;
          cnt_q <= cnt_new;
        end
      end
      if (cmd_i.div_ratio) begin
        dcnt_q <= RATIO_STEPS;
      end else if (cmd_i.div_sum) begin
        dcnt_q <= SUM_STEPS;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - DCNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      supply_q <= supply_sample_i[SAMPLE_WIDTH-1:0];
      sense_q  <= sense_sample_i[SAMPLE_WIDTH-1:0];
    end
    if (cmd_i.div_ratio) begin
      rem_q  <= DIV_W'(diff);
      dvd_q  <= '0;
      dsor_q <= DIV_W'(supply_q);
    end else if (cmd_i.div_sum) begin
      rem_q  <= '0;
      dvd_q  <= {sum_new, {(DVD_W-SUM_W){1'b0}}};
      dsor_q <= DIV_W'(cnt_new);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], rem_ge};
    end
    if (cmd_i.mul_r || cmd_i.mul_q) begin
      prod_q <= prod_d;
    end
    if (cmd_i.take_v) begin
      v_q <= prod_q[PROD_W-1:13];
    end else if (cmd_i.zero_v) begin
      v_q <= '0;
    end
    if (cmd_i.filt) begin
      if (!mode_q) begin
        res_q <= SUM_W'(held_half);
      end else if (leaky) begin
        res_q <= avg;
      end else begin
        res_q <= '0;
      end
    end else if (cmd_i.take_quot) begin
      res_q <= dvd_q[SUM_W-1:0];
    end
    if (cmd_i.out_load) begin
      level_q <= (res_q > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX : res_q[LEVEL_W-1:0];
    end
  end

`ifndef SYNTHESIS
  // window count never grows beyond the largest window
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(128))
    else $error("window count out of range");

  // divider only steps while it has steps left
  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (dcnt_q != '0))
    else $error("divider stepped past its end");

  // saturation holds on every loaded result
  a_level_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (level_q <= LEVEL_MAX))
    else $error("light level above saturation");
`endif

endmodule

`default_nettype wire

// ----- hdl/light_level_ratio_filter_top.sv -----
// top level of the light level ratio filter
//
// Input channel (in_valid_i/in_ready_o) takes one supply and one sense sample
// per transaction; output channel (out_valid_o/out_ready_i) returns one
// smoothed light_level per input transaction, in order.
// Configuration channel (cfg_valid_i/cfg_ready_o) is always ready: index 0 is
// filter_mode, index 1 is average_shift; other indexes are ignored.
// Each item passes through the 16-step shared restoring divider that forms
// the (supply - sense) / supply ratio, plus two passes through the shared
// 16x16 multiplier. When the mapped value is zero (sense not below supply,
// or sense zero) the divider is skipped. In running average mode during
// warm-up the same divider also forms the sum / count quotient.
// One item is in work at a time; the next is accepted the cycle after the
// result has moved into the output register, even while that result still
// waits.
// If the receiver stalls with a result pending, a new result waits in the
// datapath until the output register frees up.
// Reset clears the filter state, sets filter_mode 0 and average_shift 2.
`default_nettype none

module light_level_ratio_filter_top #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [15:0] supply_sample_i,
  input  wire  [15:0] sense_sample_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [18:0] light_level_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [3:0]  cfg_index_i,
  input  wire  [7:0]  cfg_data_i
);
  import llrf_pkg::*;

  cmd_t    cmd;
  status_t status;

  // configuration writes are always accepted
  assign cfg_ready_o = 1'b1;

  // sequencer
  llrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  llrf_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .supply_sample_i (supply_sample_i),
    .sense_sample_i  (sense_sample_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .light_level_o   (light_level_o)
  );

endmodule

`default_nettype wire
